/* hdl/rcsb_pkg.sv */
// shared types and constants for the rounded corner sprite blend core
// no dependencies
package rcsb_pkg;

    localparam int PIX_W   = 32;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int RAD_W   = 7;
    localparam int DELTA_W = 13;
    localparam int THR_W   = 16;
    localparam int ROOT_W  = 16;
    localparam int REM_W   = 32;
    localparam int D2_W    = 2 * DELTA_W + 1;
    localparam int D2R_W   = 14;
    localparam int FRAC_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 8'd3;

    localparam logic [1:0] MODE_SKIP   = 2'd0;
    localparam logic [1:0] MODE_COPY   = 2'd1;
    localparam logic [1:0] MODE_CORNER = 2'd2;
    localparam logic [1:0] MODE_BLEND  = 2'd3;

    localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'hFF;
    localparam logic [CHAN_W-1:0] HALF_PIX  = 8'h80;

    typedef struct packed {
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        logic [1:0]       mode;
    } side_t;

endpackage

/* hdl/rcsb_front.sv */
// corner classification, squared distance and threshold tests, three stages
// depends on rcsb_pkg
module rcsb_front
    import rcsb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  col_pos,
    input  logic [POS_W-1:0]  row_pos,
    input  logic [PIX_W-1:0]  src_pixel,
    input  logic [PIX_W-1:0]  dest_pixel,
    input  logic [DIM_W-1:0]  sprite_width,
    input  logic [DIM_W-1:0]  sprite_height,
    input  logic [RAD_W-1:0]  corner_radius,
    input  logic [PIX_W-1:0]  key_pixel,
    output logic              out_valid,
    input  logic              out_ready,
    output side_t             out_side,
    output logic [REM_W-1:0]  out_rem
);

    localparam int SPAN_W = DIM_W + 1;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;
    side_t side1_reg, side2_reg, side3_reg;
    logic [DELTA_W-1:0] dx1_reg, dy1_reg;
    logic [2*DELTA_W-1:0] dxsq_reg, dysq_reg;
    logic [THR_W-1:0] lo_sq_reg, hi_sq_reg;
    logic [REM_W-1:0] rem3_reg;

    logic signed [SPAN_W-1:0] wr_s, hr_s, px_s, py_s, rx_s, by_s;
    logic [POS_W-1:0] rad_pos;
    logic left, top, right, bottom;
    logic [DELTA_W-1:0] lx, ty, dx_next, dy_next;
    logic [1:0] mode_next;

    logic [RAD_W-1:0] lo_root;
    logic [RAD_W:0] hi_root;
    logic [THR_W-1:0] lo_sq, hi_sq;

    logic [D2_W-1:0] d2;
    side_t side3_next;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // corner region tests
    always_comb begin
        rad_pos = {{(POS_W-RAD_W){1'b0}}, corner_radius};
        wr_s = $signed({1'b0, sprite_width}) - $signed({{(SPAN_W-RAD_W){1'b0}}, corner_radius});
        hr_s = $signed({1'b0, sprite_height}) - $signed({{(SPAN_W-RAD_W){1'b0}}, corner_radius});
        px_s = $signed({{(SPAN_W-POS_W){1'b0}}, col_pos});
        py_s = $signed({{(SPAN_W-POS_W){1'b0}}, row_pos});
        rx_s = px_s - wr_s + SPAN_W'(1);
        by_s = py_s - hr_s + SPAN_W'(1);
        left   = col_pos < rad_pos;
        top    = row_pos < rad_pos;
        right  = px_s >= wr_s;
        bottom = py_s >= hr_s;
        lx = {{(DELTA_W-RAD_W){1'b0}}, RAD_W'(corner_radius - col_pos[RAD_W-1:0])};
        ty = {{(DELTA_W-RAD_W){1'b0}}, RAD_W'(corner_radius - row_pos[RAD_W-1:0])};
        dx_next = lx;
        dy_next = ty;
        mode_next = MODE_CORNER;
        if (left && top) begin
            dx_next = lx;
            dy_next = ty;
        end else if (right && top) begin
            dx_next = rx_s[DELTA_W-1:0];
            dy_next = ty;
        end else if (left && bottom) begin
            dx_next = lx;
            dy_next = by_s[DELTA_W-1:0];
        end else if (right && bottom) begin
            dx_next = rx_s[DELTA_W-1:0];
            dy_next = by_s[DELTA_W-1:0];
        end else begin
            mode_next = MODE_COPY;
        end
        if (src_pixel == key_pixel) begin
            mode_next = MODE_SKIP;
        end
    end

    // band limits around the radius
    always_comb begin
        lo_root = (corner_radius == '0) ? RAD_W'(1) : RAD_W'(corner_radius - RAD_W'(1));
        hi_root = {1'b0, corner_radius} + (RAD_W+1)'(1);
        lo_sq = {{(THR_W-RAD_W){1'b0}}, lo_root} * {{(THR_W-RAD_W){1'b0}}, lo_root};
        hi_sq = {{(THR_W-RAD_W-1){1'b0}}, hi_root} * {{(THR_W-RAD_W-1){1'b0}}, hi_root};
    end

    always_comb begin
        d2 = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
        side3_next = side2_reg;
        if (side2_reg.mode == MODE_CORNER) begin
            if (d2 <= {{(D2_W-THR_W){1'b0}}, lo_sq_reg}) begin
                side3_next.mode = MODE_COPY;
            end else if (d2 >= {{(D2_W-THR_W){1'b0}}, hi_sq_reg}) begin
                side3_next.mode = MODE_SKIP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            side1_reg.src  <= src_pixel;
            side1_reg.dst  <= dest_pixel;
            side1_reg.mode <= mode_next;
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
        end
        if (en2) begin
            side2_reg <= side1_reg;
            dxsq_reg  <= dx1_reg * dx1_reg;
            dysq_reg  <= dy1_reg * dy1_reg;
            lo_sq_reg <= lo_sq;
            hi_sq_reg <= hi_sq;
        end
        if (en3) begin
            side3_reg <= side3_next;
            rem3_reg  <= {{(REM_W-D2R_W-FRAC_W){1'b0}}, d2[D2R_W-1:0], {FRAC_W{1'b0}}};
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_rem   = rem3_reg;

endmodule

/* hdl/rcsb_root_cell.sv */
// one bit of the 8.8 square root: trial subtract against the remainder
// depends on rcsb_pkg
module rcsb_root_cell
    import rcsb_pkg::*;
#(
    parameter int BIT = 0
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  side_t             in_side,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [ROOT_W-1:0] in_root,
    output logic              out_valid,
    input  logic              out_ready,
    output side_t             out_side,
    output logic [REM_W-1:0]  out_rem,
    output logic [ROOT_W-1:0] out_root
);

    logic v_reg;
    side_t side_reg;
    logic [REM_W-1:0] rem_reg, rem_next, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic take;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        trial = (REM_W'(in_root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
        take  = trial <= in_rem;
        rem_next  = take ? in_rem - trial : in_rem;
        root_next = take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

/* hdl/rcsb_back.sv */
// alpha from the root, per channel blend and the output register
// depends on rcsb_pkg
module rcsb_back
    import rcsb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  side_t             in_side,
    input  logic [ROOT_W-1:0] in_root,
    input  logic [RAD_W-1:0]  corner_radius,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_enable,
    output logic [PIX_W-1:0]  m_pixel_out
);

    localparam int ACC_W = ROOT_W + 1;
    localparam int PROD_W = 2 * CHAN_W;
    localparam int SUM_W = PROD_W + 1;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;
    side_t side1_reg, side2_reg, side1_next;
    logic [CHAN_W-1:0] alpha_reg, alpha_next, inv_alpha;
    logic [PROD_W-1:0] sprod_reg [NCHAN];
    logic [PROD_W-1:0] dprod_reg [NCHAN];
    logic [SUM_W-1:0] sum [NCHAN];
    logic [PIX_W-1:0] blend_pix;
    logic signed [ACC_W-1:0] a_s;
    logic we_reg;
    logic [PIX_W-1:0] pix_reg, pix_next;

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        a_s = $signed({2'b00, corner_radius, HALF_PIX}) - $signed({1'b0, in_root});
        side1_next = in_side;
        alpha_next = ALPHA_MAX;
        if (in_side.mode == MODE_CORNER) begin
            if (a_s <= 0) begin
                side1_next.mode = MODE_SKIP;
            end else if (a_s >= $signed(ACC_W'(ALPHA_MAX))) begin
                side1_next.mode = MODE_COPY;
            end else begin
                side1_next.mode = MODE_BLEND;
                alpha_next = a_s[CHAN_W-1:0];
            end
        end
    end

    assign inv_alpha = ALPHA_MAX - alpha_reg;

    always_comb begin
        blend_pix = '0;
        for (int c = 0; c < NCHAN; c++) begin
            sum[c] = {1'b0, sprod_reg[c]} + {1'b0, dprod_reg[c]} + SUM_W'(HALF_PIX);
            blend_pix[c*CHAN_W +: CHAN_W] = sum[c][CHAN_W +: CHAN_W];
        end
        case (side2_reg.mode)
            MODE_COPY:  pix_next = side2_reg.src;
            MODE_BLEND: pix_next = blend_pix;
            default:    pix_next = side2_reg.dst;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            side1_reg <= side1_next;
            alpha_reg <= alpha_next;
        end
        if (en2) begin
            side2_reg <= side1_reg;
            for (int c = 0; c < NCHAN; c++) begin
                sprod_reg[c] <= side1_reg.src[c*CHAN_W +: CHAN_W] * alpha_reg;
                dprod_reg[c] <= side1_reg.dst[c*CHAN_W +: CHAN_W] * inv_alpha;
            end
        end
        if (en3) begin
            we_reg  <= side2_reg.mode != MODE_SKIP;
            pix_reg <= pix_next;
        end
    end

    assign m_valid        = v3_reg;
    assign m_write_enable = we_reg;
    assign m_pixel_out    = pix_reg;

endmodule

/* hdl/rounded_corner_sprite_blend_core.sv */
// top level: configuration registers, front stages, square root cell row, blend stages
// depends on rcsb_pkg, rcsb_front, rcsb_root_cell, rcsb_back
// takes one pixel word per clock while s_ready is high and returns one result word per
// pixel, passing through three front stages (corner test, squares, band test), a row of
// 16 root cells that settle one bit of the 8.8 distance each, and three blend stages
// (alpha, channel products, rounding into the output register). every stage has its
// own valid bit, so a held output only stops the stages behind occupied ones and
// s_ready stays high while any bubble remains. configuration writes take effect at
// once and are meant for idle periods; no clearing pass after reset.
module rounded_corner_sprite_blend_core
    import rcsb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [POS_W-1:0]     s_col_pos,
    input  logic [POS_W-1:0]     s_row_pos,
    input  logic [PIX_W-1:0]     s_src_pixel,
    input  logic [PIX_W-1:0]     s_dest_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_write_enable,
    output logic [PIX_W-1:0]     m_pixel_out
);

    logic [DIM_W-1:0] width_reg, height_reg, dim_next;
    logic [RAD_W-1:0] radius_reg;
    logic [PIX_W-1:0] key_reg;

    logic              cv [ROOT_W+1];
    logic              cr [ROOT_W+1];
    side_t             cside [ROOT_W+1];
    logic [REM_W-1:0]  crem [ROOT_W+1];
    logic [ROOT_W-1:0] croot [ROOT_W+1];

    assign dim_next = (cfg_data[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : cfg_data[DIM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd64;
            height_reg <= 13'd64;
            radius_reg <= '0;
            key_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= dim_next;
                CFG_HEIGHT: height_reg <= dim_next;
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_KEY:    key_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    rcsb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .col_pos       (s_col_pos),
        .row_pos       (s_row_pos),
        .src_pixel     (s_src_pixel),
        .dest_pixel    (s_dest_pixel),
        .sprite_width  (width_reg),
        .sprite_height (height_reg),
        .corner_radius (radius_reg),
        .key_pixel     (key_reg),
        .out_valid     (cv[0]),
        .out_ready     (cr[0]),
        .out_side      (cside[0]),
        .out_rem       (crem[0])
    );

    assign croot[0] = '0;

    // root bits settle msb first along the row
    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        rcsb_root_cell #(
            .BIT (ROOT_W - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_side   (cside[i]),
            .in_rem    (crem[i]),
            .in_root   (croot[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_side  (cside[i+1]),
            .out_rem   (crem[i+1]),
            .out_root  (croot[i+1])
        );
    end

    rcsb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (cv[ROOT_W]),
        .in_ready       (cr[ROOT_W]),
        .in_side        (cside[ROOT_W]),
        .in_root        (croot[ROOT_W]),
        .corner_radius  (radius_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_pixel_out    (m_pixel_out)
    );

endmodule
